// ===== design/bfpa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfpa_pkg
// Shared constants and types of the best-fit page range allocator.
// ----------------------------------------------------------------------------
package bfpa_pkg;

    localparam int DEF_NUM_PAGES = 512;

    localparam int FUNC_W    = 3;
    localparam int PAGE_W    = 9;
    localparam int COUNT_W   = 10;
    localparam int REPORT_W  = 10;

    localparam logic [FUNC_W-1:0] FN_ALLOC    = 3'd0;
    localparam logic [FUNC_W-1:0] FN_RELEASE  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_COMMIT   = 3'd2;
    localparam logic [FUNC_W-1:0] FN_DECOMMIT = 3'd3;
    localparam logic [FUNC_W-1:0] FN_LOOKUP   = 3'd4;

    typedef struct packed {
        logic vld;
        logic free;
        logic last;
        logic start;
    } t_scan_ctl;

endpackage

// ===== design/bfpa_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfpa_req_if
// Request channel: one word per operation.
// ----------------------------------------------------------------------------
interface bfpa_req_if
    import bfpa_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [PAGE_W-1:0]   page;
    logic [COUNT_W-1:0]  count;

    modport source (output valid, func, page, count, input ready);
    modport sink   (input valid, func, page, count, output ready);
endinterface

// ===== design/bfpa_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfpa_rsp_if
// Response channel: one word per operation.
// ----------------------------------------------------------------------------
interface bfpa_rsp_if
    import bfpa_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 ok;
    logic [PAGE_W-1:0]    page_result;
    logic [REPORT_W-1:0]  pages_changed;
    logic [REPORT_W-1:0]  reserved_pages;
    logic [REPORT_W-1:0]  reserved_peak;
    logic [REPORT_W-1:0]  committed_pages;
    logic [REPORT_W-1:0]  committed_peak;

    modport source (output valid, ok, page_result, pages_changed, reserved_pages,
                    reserved_peak, committed_pages, committed_peak, input ready);
    modport sink   (input valid, ok, page_result, pages_changed, reserved_pages,
                    reserved_peak, committed_pages, committed_peak, output ready);
endinterface

// ===== design/bfpa_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfpa_scan
// Free run tracker: one page a cycle, keeps the smallest fitting run.
// ----------------------------------------------------------------------------
module bfpa_scan
    import bfpa_pkg::*;
#(
    parameter int NUM_PAGES = DEF_NUM_PAGES
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  t_scan_ctl                            i_ctl,
    input  logic [$clog2(NUM_PAGES)-1:0]         i_page,
    input  logic [$clog2(NUM_PAGES+1)-1:0]       i_need,
    output logic                                 o_found,
    output logic [$clog2(NUM_PAGES)-1:0]         o_best_start
);
    localparam int AW = $clog2(NUM_PAGES);
    localparam int CW = $clog2(NUM_PAGES + 1);

    logic [AW-1:0] r_run_start, n_run_start;
    logic [CW-1:0] r_run_len,   n_run_len;
    logic [AW-1:0] r_best_start, n_best_start;
    logic [CW-1:0] r_best_len,  n_best_len;
    logic          r_found,     n_found;
    logic [CW-1:0] cur_len;
    logic [AW-1:0] cur_start;

    always_comb begin
        cur_len      = i_ctl.free ? r_run_len + CW'(1) : r_run_len;
        cur_start    = (i_ctl.free && r_run_len == '0) ? i_page : r_run_start;
        n_run_start  = r_run_start;
        n_run_len    = r_run_len;
        n_best_start = r_best_start;
        n_best_len   = r_best_len;
        n_found      = r_found;
        if (i_ctl.start) begin
            n_run_len = '0;
            n_found   = 1'b0;
        end else if (i_ctl.vld) begin
            n_run_start = cur_start;
            n_run_len   = i_ctl.free ? cur_len : '0;
            if ((!i_ctl.free || i_ctl.last) && cur_len >= i_need
                && (!r_found || cur_len < r_best_len)) begin
                n_found      = 1'b1;
                n_best_start = cur_start;
                n_best_len   = cur_len;
            end
            if (i_ctl.last) begin
                n_run_len = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_len <= '0;
            r_found   <= 1'b0;
        end else begin
            r_run_len <= n_run_len;
            r_found   <= n_found;
        end
        r_run_start  <= n_run_start;
        r_best_start <= n_best_start;
        r_best_len   <= n_best_len;
    end

    assign o_found      = r_found;
    assign o_best_start = r_best_start;

endmodule

// ===== design/best_fit_page_range_allocator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// best_fit_page_range_allocator_core
// Best-fit page allocator with an owner tag and a commit bit per page.
// ----------------------------------------------------------------------------
// One word at a time. After reset the page map is swept clear, page by page,
// before the first request is taken. Allocate reads every page once through
// the single map port, then, if a fitting run is found, rewrites count pages.
// Release, commit and decommit read and rewrite each page in range; lookup
// reads one page if it is in range. The map port takes one read and one write
// per cycle. A finished response waits in an output register while the next
// request is taken.
// ----------------------------------------------------------------------------
module best_fit_page_range_allocator_core
    import bfpa_pkg::*;
#(
    parameter int NUM_PAGES = DEF_NUM_PAGES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bfpa_req_if.sink    i_req,
    bfpa_rsp_if.source  o_rsp
);
    localparam int AW   = $clog2(NUM_PAGES);
    localparam int CW   = $clog2(NUM_PAGES + 1);
    localparam int WW   = AW + 2;
    localparam int CMPW = (CW > COUNT_W) ? CW : COUNT_W;
    localparam int EW   = CMPW + 1;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_SWEEP = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [WW-1:0] r_map [NUM_PAGES];
    logic [WW-1:0] r_rdata;

    logic [2:0]         r_state, n_state;
    logic [FUNC_W-1:0]  r_op, n_op;
    logic [COUNT_W-1:0] r_need, n_need;
    logic [AW-1:0]      r_iss_addr, n_iss_addr;
    logic [CW-1:0]      r_iss_left, n_iss_left;
    logic               r_d_vld, n_d_vld;
    logic [AW-1:0]      r_d_addr, n_d_addr;
    logic [AW-1:0]      r_clr, n_clr;
    logic               r_ok, n_ok;
    logic [AW-1:0]      r_page, n_page;
    logic [CW-1:0]      r_changed, n_changed;
    logic [CW-1:0]      r_rcnt, n_rcnt, r_rpeak, n_rpeak;
    logic [CW-1:0]      r_ccnt, n_ccnt, r_cpeak, n_cpeak;
    logic               r_o_vld, n_o_vld;
    logic               r_o_ok;
    logic [AW-1:0]      r_o_page;
    logic [CW-1:0]      r_o_changed, r_o_rcnt, r_o_rpeak, r_o_ccnt, r_o_cpeak;

    logic          re, we;
    logic [AW-1:0] waddr;
    logic [WW-1:0] wdata;
    logic          d_commit, d_owned;
    logic [EW-1:0] page_x, end_x, lim_x, len_x;
    logic          page_in;
    logic          iss_done, o_load;
    t_scan_ctl     scan_ctl;
    logic          scan_found;
    logic [AW-1:0] scan_best;

    assign d_commit = r_rdata[WW-1];
    assign d_owned  = r_rdata[WW-2];
    assign page_x   = EW'(i_req.page);
    assign end_x    = page_x + EW'(i_req.count);
    assign lim_x    = (end_x > EW'(NUM_PAGES)) ? EW'(NUM_PAGES) : end_x;
    assign page_in  = page_x < EW'(NUM_PAGES);
    assign len_x    = page_in ? lim_x - page_x : '0;
    assign iss_done = (r_iss_left == '0) && !r_d_vld;
    assign re       = (r_state == S_SCAN || r_state == S_SWEEP) && r_iss_left != '0;
    assign o_load   = (r_state == S_FIN) && (!r_o_vld || o_rsp.ready);

    assign scan_ctl.vld   = r_d_vld && r_state == S_SCAN;
    assign scan_ctl.free  = !d_owned;
    assign scan_ctl.last  = r_d_addr == AW'(NUM_PAGES - 1);
    assign scan_ctl.start = i_req.valid && i_req.ready;

    bfpa_scan #(.NUM_PAGES(NUM_PAGES)) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (scan_ctl),
        .i_page       (r_d_addr),
        .i_need       (CW'(r_need)),
        .o_found      (scan_found),
        .o_best_start (scan_best)
    );

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_need     = r_need;
        n_iss_addr = r_iss_addr;
        n_iss_left = r_iss_left;
        n_d_vld    = 1'b0;
        n_d_addr   = r_iss_addr;
        n_clr      = r_clr;
        n_ok       = r_ok;
        n_page     = r_page;
        n_changed  = r_changed;
        n_rcnt     = r_rcnt;
        n_rpeak    = r_rpeak;
        n_ccnt     = r_ccnt;
        n_cpeak    = r_cpeak;
        n_o_vld    = r_o_vld && !o_rsp.ready;
        we         = 1'b0;
        waddr      = r_d_addr;
        wdata      = r_rdata;

        if (re) begin
            n_d_vld    = 1'b1;
            n_iss_addr = r_iss_addr + AW'(1);
            n_iss_left = r_iss_left - CW'(1);
        end

        if (r_d_vld && r_state == S_SWEEP) begin
            unique case (r_op)
                FN_ALLOC: begin
                    we     = 1'b1;
                    wdata  = {d_commit, 1'b1, r_page};
                    n_rcnt = r_rcnt + CW'(1);
                end
                FN_RELEASE: begin
                    we    = 1'b1;
                    wdata = '0;
                    if (d_commit) begin
                        n_changed = r_changed + CW'(1);
                        if (r_ccnt != '0) n_ccnt = r_ccnt - CW'(1);
                    end
                    if (d_owned && r_rcnt != '0) n_rcnt = r_rcnt - CW'(1);
                end
                FN_COMMIT: begin
                    we    = 1'b1;
                    wdata = {1'b1, r_rdata[WW-2:0]};
                    if (!d_commit) begin
                        n_changed = r_changed + CW'(1);
                        n_ccnt    = r_ccnt + CW'(1);
                    end
                end
                FN_DECOMMIT: begin
                    we    = 1'b1;
                    wdata = {1'b0, r_rdata[WW-2:0]};
                    if (d_commit) begin
                        n_changed = r_changed + CW'(1);
                        if (r_ccnt != '0) n_ccnt = r_ccnt - CW'(1);
                    end
                end
                default: begin
                    n_ok   = d_owned;
                    n_page = d_owned ? r_rdata[AW-1:0] : '0;
                end
            endcase
        end
        if (n_rcnt > r_rpeak) n_rpeak = n_rcnt;
        if (n_ccnt > r_cpeak) n_cpeak = n_ccnt;

        unique case (r_state)
            S_CLEAR: begin
                we    = 1'b1;
                waddr = r_clr;
                wdata = '0;
                n_clr = r_clr + AW'(1);
                if (r_clr == AW'(NUM_PAGES - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_op      = i_req.func;
                    n_need    = i_req.count;
                    n_ok      = 1'b0;
                    n_page    = '0;
                    n_changed = '0;
                    n_state   = S_FIN;
                    unique case (i_req.func)
                        FN_ALLOC: begin
                            if (i_req.count != '0
                                && CMPW'(i_req.count) <= CMPW'(NUM_PAGES)) begin
                                n_iss_addr = '0;
                                n_iss_left = CW'(NUM_PAGES);
                                n_state    = S_SCAN;
                            end
                        end
                        FN_RELEASE, FN_COMMIT, FN_DECOMMIT: begin
                            n_ok       = 1'b1;
                            n_iss_addr = AW'(i_req.page);
                            n_iss_left = CW'(len_x);
                            n_state    = S_SWEEP;
                        end
                        FN_LOOKUP: begin
                            if (page_in) begin
                                n_iss_addr = AW'(i_req.page);
                                n_iss_left = CW'(1);
                                n_state    = S_SWEEP;
                            end
                        end
                        default: n_state = S_FIN;
                    endcase
                end
            end
            S_SCAN: begin
                if (iss_done) begin
                    n_state = S_FIN;
                    if (scan_found) begin
                        n_ok       = 1'b1;
                        n_page     = scan_best;
                        n_iss_addr = scan_best;
                        n_iss_left = CW'(r_need);
                        n_state    = S_SWEEP;
                    end
                end
            end
            S_SWEEP: begin
                if (iss_done) n_state = S_FIN;
            end
            S_FIN: begin
                if (o_load) begin
                    n_o_vld = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) r_map[waddr] <= wdata;
        if (re) r_rdata <= r_map[r_iss_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr      <= '0;
            r_iss_left <= '0;
            r_d_vld    <= 1'b0;
            r_rcnt     <= '0;
            r_rpeak    <= '0;
            r_ccnt     <= '0;
            r_cpeak    <= '0;
            r_o_vld    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr      <= n_clr;
            r_iss_left <= n_iss_left;
            r_d_vld    <= n_d_vld;
            r_rcnt     <= n_rcnt;
            r_rpeak    <= n_rpeak;
            r_ccnt     <= n_ccnt;
            r_cpeak    <= n_cpeak;
            r_o_vld    <= n_o_vld;
        end
        r_op       <= n_op;
        r_need     <= n_need;
        r_iss_addr <= n_iss_addr;
        r_d_addr   <= n_d_addr;
        r_ok       <= n_ok;
        r_page     <= n_page;
        r_changed  <= n_changed;
        if (o_load) begin
            r_o_ok      <= r_ok;
            r_o_page    <= r_page;
            r_o_changed <= r_changed;
            r_o_rcnt    <= r_rcnt;
            r_o_rpeak   <= r_rpeak;
            r_o_ccnt    <= r_ccnt;
            r_o_cpeak   <= r_cpeak;
        end
    end

    assign i_req.ready           = r_state == S_IDLE;
    assign o_rsp.valid           = r_o_vld;
    assign o_rsp.ok              = r_o_ok;
    assign o_rsp.page_result     = PAGE_W'(r_o_page);
    assign o_rsp.pages_changed   = REPORT_W'(r_o_changed);
    assign o_rsp.reserved_pages  = REPORT_W'(r_o_rcnt);
    assign o_rsp.reserved_peak   = REPORT_W'(r_o_rpeak);
    assign o_rsp.committed_pages = REPORT_W'(r_o_ccnt);
    assign o_rsp.committed_peak  = REPORT_W'(r_o_cpeak);

    a_rpeak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rcnt <= r_rpeak) else $error("reserved count above its peak");
    a_cpeak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ccnt <= r_cpeak) else $error("committed count above its peak");
    a_dvld: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d_vld |-> (r_state == S_SCAN || r_state == S_SWEEP))
        else $error("map data outside a pass");
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLEAR |-> !i_req.ready) else $error("request taken while clearing");

endmodule

// ===== verif/best_fit_page_range_allocator_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// best_fit_page_range_allocator_core_tb
// Self-checking bench: drives allocate, release, commit, decommit, lookup and
// unused-code words, predicts every response from a local page map and compares fields.
// ----------------------------------------------------------------------------
module best_fit_page_range_allocator_core_tb;
    import bfpa_pkg::*;

    localparam int NPG = DEF_NUM_PAGES;

    typedef struct packed {
        logic                ok;
        logic [PAGE_W-1:0]   page_result;
        logic [REPORT_W-1:0] pages_changed;
        logic [REPORT_W-1:0] reserved_pages;
        logic [REPORT_W-1:0] reserved_peak;
        logic [REPORT_W-1:0] committed_pages;
        logic [REPORT_W-1:0] committed_peak;
    } t_alloc_rsp;

    class alloc_scoreboard;
        int unsigned owner_tag [NPG];
        bit          committed [NPG];
        int unsigned rsv_cnt, rsv_peak, cmt_cnt, cmt_peak;
        t_alloc_rsp  pending_rsps[$];
        int unsigned errors;
        int unsigned checked;

        function void clear_pages();
            foreach (owner_tag[k]) begin
                owner_tag[k] = 0;
                committed[k] = 1'b0;
            end
            rsv_cnt = 0; rsv_peak = 0; cmt_cnt = 0; cmt_peak = 0;
            errors = 0; checked = 0;
        endfunction

        function int unsigned set_range(int unsigned s, int unsigned n, bit v);
            int unsigned chg, e;
            chg = 0;
            e = (s + n > NPG) ? NPG : s + n;
            for (int unsigned k = s; k < e; k++) begin
                if (committed[k] != v) begin
                    committed[k] = v;
                    chg++;
                    if (v) begin
                        cmt_cnt++;
                        if (cmt_cnt > cmt_peak) cmt_peak = cmt_cnt;
                    end else if (cmt_cnt > 0) begin
                        cmt_cnt--;
                    end
                end
            end
            return chg;
        endfunction

        function void note_request(logic [FUNC_W-1:0] fn, logic [PAGE_W-1:0] pg,
                                   logic [COUNT_W-1:0] cnt);
            t_alloc_rsp r;
            int unsigned k, s, len, best_s, best_len, e;
            int unsigned pg_u, cnt_u;
            bit found;
            r = '0;
            pg_u  = 32'(pg);
            cnt_u = 32'(cnt);
            case (fn)
                FN_ALLOC: begin
                    found = 1'b0; best_s = 0; best_len = 0; k = 0;
                    if (cnt_u != 0 && cnt_u <= NPG) begin
                        while (k < NPG) begin
                            if (owner_tag[k] != 0) begin
                                k++;
                            end else begin
                                s = k;
                                while (k < NPG && owner_tag[k] == 0) k++;
                                len = k - s;
                                if (len >= cnt_u && (!found || len < best_len)) begin
                                    found = 1'b1; best_s = s; best_len = len;
                                end
                            end
                        end
                    end
                    if (found) begin
                        for (k = 0; k < cnt_u; k++) owner_tag[best_s + k] = best_s + 1;
                        rsv_cnt += cnt_u;
                        if (rsv_cnt > rsv_peak) rsv_peak = rsv_cnt;
                        r.ok = 1'b1;
                        r.page_result = PAGE_W'(best_s);
                    end
                end
                FN_RELEASE: begin
                    r.pages_changed = REPORT_W'(set_range(pg_u, cnt_u, 1'b0));
                    e = (pg_u + cnt_u > NPG) ? NPG : pg_u + cnt_u;
                    for (k = pg_u; k < e; k++) begin
                        if (owner_tag[k] != 0) begin
                            owner_tag[k] = 0;
                            if (rsv_cnt > 0) rsv_cnt--;
                        end
                    end
                    r.ok = 1'b1;
                end
                FN_COMMIT: begin
                    r.pages_changed = REPORT_W'(set_range(pg_u, cnt_u, 1'b1));
                    r.ok = 1'b1;
                end
                FN_DECOMMIT: begin
                    r.pages_changed = REPORT_W'(set_range(pg_u, cnt_u, 1'b0));
                    r.ok = 1'b1;
                end
                FN_LOOKUP: begin
                    if (pg_u < NPG && owner_tag[pg_u] != 0) begin
                        r.ok = 1'b1;
                        r.page_result = PAGE_W'(owner_tag[pg_u] - 1);
                    end
                end
                default: ;
            endcase
            r.reserved_pages  = REPORT_W'(rsv_cnt);
            r.reserved_peak   = REPORT_W'(rsv_peak);
            r.committed_pages = REPORT_W'(cmt_cnt);
            r.committed_peak  = REPORT_W'(cmt_peak);
            pending_rsps.push_back(r);
        endfunction

        function void check_response(t_alloc_rsp got);
            t_alloc_rsp exp;
            checked++;
            if (pending_rsps.size() == 0) begin
                errors++;
                $display("%0t: unexpected response %h", $time, got);
                return;
            end
            exp = pending_rsps.pop_front();
            if (got.ok !== exp.ok) begin
                errors++;
                $display("%0t: ok exp %0d got %0d", $time, exp.ok, got.ok);
            end
            if (got.page_result !== exp.page_result) begin
                errors++;
                $display("%0t: page_result exp %0d got %0d", $time,
                         exp.page_result, got.page_result);
            end
            if (got.pages_changed !== exp.pages_changed) begin
                errors++;
                $display("%0t: pages_changed exp %0d got %0d", $time,
                         exp.pages_changed, got.pages_changed);
            end
            if (got.reserved_pages !== exp.reserved_pages) begin
                errors++;
                $display("%0t: reserved_pages exp %0d got %0d", $time,
                         exp.reserved_pages, got.reserved_pages);
            end
            if (got.reserved_peak !== exp.reserved_peak) begin
                errors++;
                $display("%0t: reserved_peak exp %0d got %0d", $time,
                         exp.reserved_peak, got.reserved_peak);
            end
            if (got.committed_pages !== exp.committed_pages) begin
                errors++;
                $display("%0t: committed_pages exp %0d got %0d", $time,
                         exp.committed_pages, got.committed_pages);
            end
            if (got.committed_peak !== exp.committed_peak) begin
                errors++;
                $display("%0t: committed_peak exp %0d got %0d", $time,
                         exp.committed_peak, got.committed_peak);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    bfpa_req_if req_if ();
    bfpa_rsp_if rsp_if ();

    best_fit_page_range_allocator_core #(.NUM_PAGES(NPG)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    alloc_scoreboard sb;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    bit          hold_off;
    int unsigned sent;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #400ms;
        $display("CHECKS FAILED");
        $finish;
    end

    // Response sink: sample at the rising edge, update ready at the falling edge.
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            sb.check_response({rsp_if.ok, rsp_if.page_result, rsp_if.pages_changed,
                               rsp_if.reserved_pages, rsp_if.reserved_peak,
                               rsp_if.committed_pages, rsp_if.committed_peak});
        end
    end

    always @(negedge i_clk) begin
        if (hold_off) begin
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_word(logic [FUNC_W-1:0] fn, logic [PAGE_W-1:0] pg,
                             logic [COUNT_W-1:0] cnt);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.func  <= fn;
        req_if.page  <= pg;
        req_if.count <= cnt;
        do @(posedge i_clk); while (!req_if.ready);
        sb.note_request(fn, pg, cnt);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic send_random();
        int unsigned sel;
        logic [FUNC_W-1:0]  fn;
        logic [PAGE_W-1:0]  pg;
        logic [COUNT_W-1:0] cnt;
        sel = $urandom_range(99);
        pg  = PAGE_W'($urandom);
        if (sel < 30) begin
            fn = FN_ALLOC;
        end else if (sel < 45) begin
            fn = FN_RELEASE;
        end else if (sel < 62) begin
            fn = FN_COMMIT;
        end else if (sel < 75) begin
            fn = FN_DECOMMIT;
        end else if (sel < 95) begin
            fn = FN_LOOKUP;
        end else begin
            fn = FUNC_W'($urandom_range(7));
        end
        case ($urandom_range(9))
            0:       cnt = COUNT_W'($urandom);
            1:       cnt = COUNT_W'($urandom_range(512));
            2:       cnt = COUNT_W'($urandom_range(128));
            default: cnt = COUNT_W'($urandom_range(24));
        endcase
        send_word(fn, pg, cnt);
    endtask

    task automatic drain();
        int unsigned guard;
        guard = 0;
        req_if.valid <= 1'b0;
        while (sb.pending_rsps.size() != 0 && guard < 200000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (20) @(negedge i_clk);
    endtask

    initial begin
        sb = new();
        sb.clear_pages();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off       = 1'b0;
        sent           = 0;
        req_if.valid   = 1'b0;
        req_if.func    = FN_LOOKUP;
        req_if.page    = '0;
        req_if.count   = '0;
        rsp_if.ready   = 1'b0;
        i_rst_n        = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed words
        send_word(FN_ALLOC,    9'd0,   10'd0);
        send_word(FN_ALLOC,    9'd0,   10'd513);
        send_word(FN_ALLOC,    9'd0,   10'd1023);
        send_word(FN_ALLOC,    9'd0,   10'd512);
        send_word(FN_ALLOC,    9'd0,   10'd1);
        send_word(FN_COMMIT,   9'd0,   10'd512);
        send_word(FN_LOOKUP,   9'd511, 10'd0);
        send_word(FN_RELEASE,  9'd500, 10'd1023);
        send_word(FN_RELEASE,  9'd0,   10'd100);
        send_word(FN_RELEASE,  9'd0,   10'd100);
        send_word(FN_ALLOC,    9'd0,   10'd10);
        send_word(FN_ALLOC,    9'd0,   10'd20);
        send_word(FN_ALLOC,    9'd0,   10'd5);
        send_word(FN_LOOKUP,   9'd3,   10'd0);
        send_word(FN_LOOKUP,   9'd200, 10'd0);
        send_word(FN_DECOMMIT, 9'd100, 10'd300);
        send_word(FN_DECOMMIT, 9'd100, 10'd300);
        send_word(FN_COMMIT,   9'd511, 10'd1023);
        send_word(FN_RELEASE,  9'd10,  10'd20);
        send_word(FN_ALLOC,    9'd0,   10'd8);
        // codes above lookup carry no operation
        for (int f = int'(FN_LOOKUP) + 1; f < (1 << FUNC_W); f++) begin
            send_word(FUNC_W'(f), PAGE_W'(f - 4), COUNT_W'(f - 4));
        end
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            for (int n = 0; n < 245; n++) send_random();
        end

        // hold the sink off while words keep coming
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        fork
            begin
                hold_off = 1'b1;
                repeat (3000) @(negedge i_clk);
                hold_off = 1'b0;
            end
            for (int n = 0; n < 20; n++) send_word(FN_LOOKUP, PAGE_W'($urandom), 10'd0);
        join
        drain();

        if (sb.pending_rsps.size() != 0) begin
            $display("CHECKS FAILED");
            $finish;
        end
        $display("Sent %0d request words, checked %0d responses over four idle patterns",
                 sent, sb.checked);
        $display("and a long sink hold-off; %0d field mismatches.", sb.errors);
        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
